// File: rtl/self_organizing_list_assert.svh
// assertion macros for the self-organizing list checker
// no dependencies; clk and rst must be visible where a macro is used
`ifndef SELF_ORGANIZING_LIST_ASSERT_SVH
`define SELF_ORGANIZING_LIST_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SOL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("self_organizing_list: assertion failed");

// next-cycle implication, disabled in reset
`define SOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("self_organizing_list: assertion failed");

`endif

// File: rtl/sol_pkg.sv
// shared types and constants for the self-organizing list
// no dependencies
`timescale 1ns / 1ps

package sol_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int LEN_W       = $clog2(ENTRIES + 1);
  localparam int POS_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int POLICY_W    = 2;
  localparam int S_DATA_W    = 32;
  localparam int M_DATA_W    = 16;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  localparam logic [POLICY_W-1:0] POL_TRANSPOSE = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FRONT     = 2'd1;
  localparam logic [POLICY_W-1:0] POL_COUNT     = 2'd2;
  localparam logic [POLICY_W-1:0] POL_RESET     = POL_FRONT;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_ACCESS = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_MOVE
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// File: rtl/self_organizing_list.sv
// top level of the self-organizing list: control, cell chain, output register
// depends on sol_pkg and sol_cell
`timescale 1ns / 1ps

// Self-organizing list of up to 16 keys. Append beats (tuser 0) add a key at the
// tail; access beats (tuser 1) find the first equal key from the head and reorder
// it by the policy register (0 transpose, 1 move to front, 2 frequency count,
// 3 no move, reset 1). In the accept cycle every cell compares its key against
// the input and the first hit is registered; in the move state the chain of
// cells shifts by one place and the moved entry is loaded at its new place,
// and one result beat is written to the output register. The next item is
// taken while a result still waits, but the move state stalls until the output
// register is free. Policy writes are taken at any time.

module self_organizing_list (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sol_pkg::S_DATA_W-1:0]    s_tdata,   // key[31:0]
  input  logic                            s_tuser,   // cmd
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sol_pkg::M_DATA_W-1:0]    m_tdata,   // status[1:0], old_position[5:2],
                                                     // new_position[9:6], zeros above
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sol_pkg::POLICY_W-1:0]    cfg_data
);
  import sol_pkg::*;

  state_t state, state_next;

  logic [POLICY_W-1:0]    policy;
  logic [LEN_W-1:0]       length;
  logic                   cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic                   hit_q;
  logic [IDX_W-1:0]       pos_q;
  logic [COUNT_WIDTH-1:0] cnt_q;

  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [POS_W-1:0]       out_old;
  logic [POS_W-1:0]       out_new;

  logic                   accept;
  logic                   slot_free;
  logic                   move_fire;

  logic [KEY_WIDTH-1:0]   cell_key   [ENTRIES];
  logic [COUNT_WIDTH-1:0] cell_count [ENTRIES];
  logic [KEY_WIDTH-1:0]   prev_key   [ENTRIES];
  logic [COUNT_WIDTH-1:0] prev_count [ENTRIES];
  logic [ENTRIES-1:0]     match;
  logic [ENTRIES-1:0]     below;
  cell_ctl_t              ctl [ENTRIES];

  logic                   hit_found;
  logic [IDX_W-1:0]       pos_found;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [IDX_W-1:0]       q_pos;
  logic [IDX_W-1:0]       dst;
  logic                   do_move;
  logic                   do_load;
  logic [KEY_WIDTH-1:0]   load_key;
  logic [COUNT_WIDTH-1:0] load_count;
  logic [STATUS_W-1:0]    res_status;
  logic [IDX_W-1:0]       res_old;
  logic [IDX_W-1:0]       res_new;
  logic                   append_ok;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !out_valid || m_tready;

  // fsm
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MOVE;
      end
      ST_MOVE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    move_fire = 1'b0;
    case (state)
      ST_IDLE: s_tready  = 1'b1;
      ST_MOVE: move_fire = slot_free;
      default: begin
        s_tready  = 1'b0;
        move_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      policy <= cfg_data;
    end
  end

  // cell chain
  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev_key[gi]   = '0;
        assign prev_count[gi] = '0;
      end else begin : g_body
        assign prev_key[gi]   = cell_key[gi-1];
        assign prev_count[gi] = cell_count[gi-1];
      end

      sol_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl[gi]),
        .prev_key   (prev_key[gi]),
        .prev_count (prev_count[gi]),
        .load_key   (load_key),
        .load_count (load_count),
        .probe_key  (s_tdata[KEY_WIDTH-1:0]),
        .ref_count  (cnt_inc),
        .key        (cell_key[gi]),
        .count      (cell_count[gi]),
        .match      (match[gi]),
        .below      (below[gi])
      );
    end
  endgenerate

  // first hit from the head among valid entries
  always_comb begin
    hit_found = 1'b0;
    pos_found = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i] && (LEN_W'(i) < length)) begin
        hit_found = 1'b1;
        pos_found = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= s_tuser;
      key_q <= s_tdata[KEY_WIDTH-1:0];
      hit_q <= hit_found;
      pos_q <= pos_found;
      cnt_q <= cell_count[pos_found];
    end
  end

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  // count mode target: just past the last entry above the hit not below the new count
  always_comb begin
    q_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((IDX_W'(i) < pos_q) && !below[i]) begin
        q_pos = IDX_W'(i + 1);
      end
    end
  end

  assign append_ok = (length < LEN_W'(ENTRIES));

  always_comb begin
    dst        = pos_q;
    do_move    = 1'b0;
    do_load    = 1'b0;
    load_key   = key_q;
    load_count = cnt_q;
    res_status = STAT_OK;
    res_old    = '0;
    res_new    = '0;
    if (cmd_q == CMD_APPEND) begin
      load_count = '0;
      if (append_ok) begin
        dst     = length[IDX_W-1:0];
        do_load = 1'b1;
        res_old = length[IDX_W-1:0];
        res_new = length[IDX_W-1:0];
      end else begin
        res_status = STAT_FULL;
      end
    end else if (!hit_q) begin
      res_status = STAT_MISS;
    end else begin
      res_old = pos_q;
      case (policy)
        POL_TRANSPOSE: begin
          dst     = (pos_q != '0) ? pos_q - 1'b1 : pos_q;
          do_move = 1'b1;
          do_load = 1'b1;
        end
        POL_FRONT: begin
          dst     = '0;
          do_move = 1'b1;
          do_load = 1'b1;
        end
        POL_COUNT: begin
          dst        = q_pos;
          load_count = cnt_inc;
          do_move    = 1'b1;
          do_load    = 1'b1;
        end
        default: begin
          dst = pos_q;
        end
      endcase
      res_new = dst;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ctl[i].shift = move_fire && do_move && (IDX_W'(i) > dst) && (IDX_W'(i) <= pos_q);
      ctl[i].load  = move_fire && do_load && (IDX_W'(i) == dst);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (move_fire && (cmd_q == CMD_APPEND) && append_ok) begin
      length <= length + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_fire) begin
      out_status <= res_status;
      out_old    <= POS_W'(res_old);
      out_new    <= POS_W'(res_new);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - STATUS_W - 2 * POS_W){1'b0}}, out_new, out_old, out_status};

endmodule

// File: rtl/sol_cell.sv
// one list entry: key and access count, shifts from its upper neighbor or loads
// depends on sol_pkg
`timescale 1ns / 1ps

module sol_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  sol_pkg::cell_ctl_t            ctl,
  input  logic [sol_pkg::KEY_WIDTH-1:0]   prev_key,
  input  logic [sol_pkg::COUNT_WIDTH-1:0] prev_count,
  input  logic [sol_pkg::KEY_WIDTH-1:0]   load_key,
  input  logic [sol_pkg::COUNT_WIDTH-1:0] load_count,
  input  logic [sol_pkg::KEY_WIDTH-1:0]   probe_key,
  input  logic [sol_pkg::COUNT_WIDTH-1:0] ref_count,
  output logic [sol_pkg::KEY_WIDTH-1:0]   key,
  output logic [sol_pkg::COUNT_WIDTH-1:0] count,
  output logic                          match,
  output logic                          below
);
  import sol_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= load_key;
    end else if (ctl.shift) begin
      key <= prev_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= load_count;
    end else if (ctl.shift) begin
      count <= prev_count;
    end
  end

  assign match = (key == probe_key);
  assign below = (count < ref_count);

endmodule

// File: rtl/sol_checker.sv
// port-level checks for the self-organizing list, bound to the top level
// depends on sol_pkg and self_organizing_list_assert.svh
`timescale 1ns / 1ps
`include "self_organizing_list_assert.svh"

module sol_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [sol_pkg::M_DATA_W-1:0] m_tdata
);
  import sol_pkg::*;

  // one item in flight: no beat right after an accepted one
  `SOL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // a new result appears only after an accepted beat, through the move state and the output register
  `SOL_ASSERT_IMPLY(a_result_caused, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

  // miss and full carry zero positions, never an unused status
  `SOL_ASSERT_IMPLY(a_status_fields,
    m_tvalid && (m_tdata[1:0] != STAT_OK),
    (m_tdata[9:2] == 8'd0) && ((m_tdata[1:0] == STAT_MISS) || (m_tdata[1:0] == STAT_FULL)))

  // stalled result holds
  `SOL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind self_organizing_list sol_checker u_sol_checker (.*);

// File: sim/tb_self_organizing_list.sv
// testbench for self_organizing_list: directed and random append/access beats under all policies
// keeps its own ordered key list with counts and checks every result beat against it
// depends on sol_pkg and the self_organizing_list rtl
`timescale 1ns / 1ps

module tb_self_organizing_list;
  import sol_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

  typedef struct packed {
    logic [5:0]          pad;
    logic [POS_W-1:0]    new_pos;
    logic [POS_W-1:0]    old_pos;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  class ordered_list;
    logic [KEY_WIDTH-1:0]   keys[ENTRIES];
    logic [COUNT_WIDTH-1:0] counts[ENTRIES];
    int                     length;
    logic [POLICY_W-1:0]    policy;
    list_result_t           results_due[$];
    int                     errors;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        keys[i]   = '0;
        counts[i] = '0;
      end
      length = 0;
      policy = POL_RESET;
      errors = 0;
    endfunction

    function void set_policy(logic [POLICY_W-1:0] p);
      policy = p;
    endfunction

    // accepted input beat: update the list and queue the result it must give
    function void take_item(logic cmd, logic [KEY_WIDTH-1:0] key);
      list_result_t           r;
      int                     p;
      int                     q;
      int                     i;
      bit                     found;
      logic [KEY_WIDTH-1:0]   k;
      logic [COUNT_WIDTH-1:0] c;
      r = '0;
      r.status = STAT_OK;
      if (cmd == CMD_APPEND) begin
        if (length >= ENTRIES) begin
          r.status = STAT_FULL;
        end else begin
          keys[length]   = key;
          counts[length] = '0;
          r.old_pos      = POS_W'(length);
          r.new_pos      = POS_W'(length);
          length++;
        end
      end else begin
        found = 0;
        p = 0;
        for (i = 0; i < length; i++) begin
          if (!found && keys[i] == key) begin
            found = 1;
            p = i;
          end
        end
        if (!found) begin
          r.status = STAT_MISS;
        end else begin
          q = p;
          case (policy)
            POL_TRANSPOSE: if (p > 0) q = p - 1;
            POL_FRONT: q = 0;
            POL_COUNT: begin
              if (counts[p] != '1) counts[p] = counts[p] + 1'b1;
              while (q > 0 && counts[q-1] < counts[p]) q--;
            end
            default: ;
          endcase
          // entry moves as a unit, the ones in between slide back one place
          k = keys[p];
          c = counts[p];
          for (i = p; i > q; i--) begin
            keys[i]   = keys[i-1];
            counts[i] = counts[i-1];
          end
          keys[q]   = k;
          counts[q] = c;
          r.old_pos = POS_W'(p);
          r.new_pos = POS_W'(q);
        end
      end
      results_due.push_back(r);
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data);
      list_result_t got;
      list_result_t want;
      got = data;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.old_pos !== want.old_pos) begin
        $display("%0t: old_position mismatch, expected %0d, actual %0d",
                 $time, want.old_pos, got.old_pos);
        errors++;
      end
      if (got.new_pos !== want.new_pos) begin
        $display("%0t: new_position mismatch, expected %0d, actual %0d",
                 $time, want.new_pos, got.new_pos);
        errors++;
      end
      if (got.pad !== want.pad) begin
        $display("%0t: padding mismatch, expected %h, actual %h", $time, want.pad, got.pad);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [POLICY_W-1:0] cfg_data;

  ordered_list board;
  bit          src_idle;
  bit          sink_stall;
  int          quiet_cycles;

  self_organizing_list u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side backpressure
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (sink_stall && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [KEY_WIDTH-1:0] key);
    int gap;
    gap = (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    board.take_item(cmd, key);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.results_due.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy(logic [POLICY_W-1:0] p);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= p;
    do @(posedge clk); while (!cfg_ready);
    board.set_policy(p);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80 && board.length > 0)
      send_item(CMD_ACCESS, board.keys[$urandom_range(0, board.length - 1)]);
    else if (sel < 93)
      send_item(CMD_ACCESS, $urandom);
    else
      send_item(CMD_APPEND, $urandom);
  endtask

  logic [POLICY_W-1:0] phase_policy[6] = '{POL_TRANSPOSE, POL_FRONT, POL_COUNT, POL_UNUSED,
                                           POL_COUNT, POL_FRONT};

  initial begin
    logic [KEY_WIDTH-1:0] head_key;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_APPEND;
    cfg_valid  = 1'b0;
    cfg_data   = POL_RESET;
    src_idle   = 1'b0;
    sink_stall = 1'b0;
    board      = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, starting with the policy at its reset value
    send_item(CMD_ACCESS, 32'h0000_0000);
    send_item(CMD_APPEND, 32'h8000_0000);
    send_item(CMD_APPEND, 32'h7fff_ffff);
    send_item(CMD_APPEND, 32'h0000_0000);
    send_item(CMD_APPEND, 32'hffff_ffff);
    send_item(CMD_APPEND, 32'h0000_0005);
    send_item(CMD_APPEND, 32'h0000_0005);
    send_item(CMD_APPEND, 32'ha5a5_a5a5);
    send_item(CMD_APPEND, 32'h5a5a_5a5a);
    send_item(CMD_ACCESS, 32'h5a5a_5a5a);
    send_item(CMD_ACCESS, 32'h5a5a_5a5a);
    send_item(CMD_ACCESS, 32'h0000_0005);
    send_item(CMD_ACCESS, 32'h1234_5678);
    write_policy(POL_TRANSPOSE);
    send_item(CMD_ACCESS, 32'h7fff_ffff);
    send_item(CMD_ACCESS, board.keys[0]);
    write_policy(POL_COUNT);
    send_item(CMD_ACCESS, 32'h0000_0000);
    send_item(CMD_ACCESS, 32'h0000_0000);
    send_item(CMD_ACCESS, 32'hffff_ffff);
    write_policy(POL_UNUSED);
    send_item(CMD_ACCESS, 32'h8000_0000);
    repeat (8) send_item(CMD_APPEND, $urandom);
    send_item(CMD_APPEND, $urandom);

    // random part, six phases over the four policy settings
    for (int ph = 0; ph < 6; ph++) begin
      write_policy(phase_policy[ph]);
      for (int n = 0; n < 80; n++) begin
        if (n % 20 == 0) begin
          src_idle   = $urandom_range(0, 3) != 0;
          sink_stall = $urandom_range(0, 3) != 0;
        end
        random_item();
      end
    end

    // last part without idling: repeated hits on the head entry, then random beats
    src_idle   = 1'b0;
    sink_stall = 1'b0;
    write_policy(POL_COUNT);
    head_key = board.keys[0];
    repeat (30) send_item(CMD_ACCESS, head_key);
    repeat (60) random_item();

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
